// ===== sv/sadm_pkg.sv =====
// Shared types and constants for the scored admission table.
// Used by the interfaces, the slot cell and the top level; no dependencies.

package sadm_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int KEY_BITS   = 32;

   // Stored key width: the request key field is 32 bits wide.
   localparam int KEY_W  = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int OCC_W  = $clog2(SLOT_COUNT + 1);

   localparam int KEY_FIELD_W   = 32;
   localparam int DELTA_W       = 16;
   localparam int SCORE_W       = 32;
   localparam int IDX_FIELD_W   = 6;
   localparam int OCC_FIELD_W   = 7;
   localparam int COUNT_W       = 32;

   typedef enum logic [1:0] {
      OUT_HIT    = 2'd0,
      OUT_ADMIT  = 2'd1,
      OUT_EVICT  = 2'd2,
      OUT_REJECT = 2'd3
   } outcome_type;

   // Search token that walks down the cell row, one cell per cycle.
   typedef struct packed {
      logic                 active;
      logic [KEY_W-1:0]     key;
      logic [DELTA_W-1:0]   delta;
      logic [SLOT_W-1:0]    victim;
      logic                 found;
      logic [SLOT_W-1:0]    hit_idx;
      logic [SCORE_W-1:0]   hit_score;
      logic                 vic_valid;
      logic [SCORE_W-1:0]   vic_score;
   } tok_type;

   // Broadcast slot write from the top level.
   typedef struct packed {
      logic                 en;
      logic [SLOT_W-1:0]    idx;
      logic                 load_key;
      logic [KEY_W-1:0]     key;
      logic [SCORE_W-1:0]   score;
   } wr_type;

   function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] score,
                                                   input logic [DELTA_W-1:0] delta);
      logic [SCORE_W:0] sum;
      sum = {1'b0, score} + {{(SCORE_W - DELTA_W + 1){1'b0}}, delta};
      if (sum[SCORE_W]) begin
         return {SCORE_W{1'b1}};
      end
      return sum[SCORE_W-1:0];
   endfunction

endpackage

// ===== sv/sadm_if.sv =====
// Handshake channels of the scored admission table: request and response.
// Depends on sadm_pkg for field widths.

interface sadm_req_if;
   import sadm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [KEY_FIELD_W-1:0]    key;
   logic [DELTA_W-1:0]        increment;

   modport source (output valid, key, increment, input ready);
   modport sink   (input valid, key, increment, output ready);
endinterface

interface sadm_rsp_if;
   import sadm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [1:0]                outcome;
   logic [IDX_FIELD_W-1:0]    slot_index;
   logic [SCORE_W-1:0]        slot_score;
   logic [OCC_FIELD_W-1:0]    slots_occupied;
   logic [COUNT_W-1:0]        contest_total;
   logic [COUNT_W-1:0]        eviction_total;

   modport source (output valid, outcome, slot_index, slot_score, slots_occupied,
                   contest_total, eviction_total, input ready);
   modport sink   (input valid, outcome, slot_index, slot_score, slots_occupied,
                   contest_total, eviction_total, output ready);
endinterface

// ===== sv/sadm_cell.sv =====
// One slot of the admission table: valid bit, key and score, plus one
// stage of the search token row. Depends on sadm_pkg.

module sadm_cell
   import sadm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [SLOT_W-1:0]  slot_id,
   input  tok_type            tok_in,
   input  wr_type             wr,
   output tok_type            tok_out
);

   logic                valid_ff, valid_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [SCORE_W-1:0]  score_ff, score_in;
   tok_type             tok_ff, tok_in_nx;
   logic                hit;
   logic [SCORE_W-1:0]  sum;

   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      score_in  = score_ff;
      tok_in_nx = tok_in;
      sum       = sat_add(score_ff, tok_in.delta);
      hit       = tok_in.active && !tok_in.found && valid_ff && (key_ff == tok_in.key);

      // capture victim slot as the token passes
      if (tok_in.active && (slot_id == tok_in.victim)) begin
         tok_in_nx.vic_valid = valid_ff;
         tok_in_nx.vic_score = score_ff;
      end
      if (hit) begin
         score_in            = sum;
         tok_in_nx.found     = 1'b1;
         tok_in_nx.hit_idx   = slot_id;
         tok_in_nx.hit_score = sum;
      end
      if (wr.en && (wr.idx == slot_id)) begin
         valid_in = 1'b1;
         score_in = wr.score;
         if (wr.load_key) begin
            key_in = wr.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      score_ff <= score_in;
   end

   assign tok_out = tok_ff;

endmodule

// ===== sv/scored_admission_table.sv =====
// Top level of the scored admission table: control, counters, response register
// and the row of slot cells. Depends on sadm_pkg, sadm_if and sadm_cell.
//
//  port     | dir | handshake        | carries
//  ---------+-----+------------------+--------------------------------------------
//  req_if   | in  | valid/ready      | key, increment
//  rsp_if   | out | valid/ready      | outcome, slot_index, slot_score,
//           |     |                  | slots_occupied, contest_total, eviction_total
//
//  After accept the search token walks the cell row one slot per cycle; in
//  ST_SWEEP the top level captures it, and in ST_FINISH it writes the slot and
//  loads the response. A new request is accepted only back in ST_IDLE.
//  Reset clears slot valid bits, victim pointer, occupancy and counters.
//  A stalled response holds; the next request is taken while it waits, and the
//  following one finishes only once the response register is free.

module scored_admission_table
   import sadm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   sadm_req_if.sink      req_if,
   sadm_rsp_if.source    rsp_if
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   state_type              state_ff;
   tok_type                tok_done_ff;
   logic [SLOT_W-1:0]      ptr_ff;
   logic [OCC_W-1:0]       occ_ff;
   logic [COUNT_W-1:0]     contest_ff;
   logic [COUNT_W-1:0]     evict_ff;

   logic                   rsp_valid_ff;
   outcome_type            outcome_ff;
   logic [IDX_FIELD_W-1:0] slot_index_ff;
   logic [SCORE_W-1:0]     slot_score_ff;
   logic [OCC_FIELD_W-1:0] occ_out_ff;
   logic [COUNT_W-1:0]     contest_out_ff;
   logic [COUNT_W-1:0]     evict_out_ff;

   tok_type                chain [SLOT_COUNT+1];
   tok_type                launch;
   wr_type                 wr;
   logic                   accept;
   logic                   out_free;
   logic                   finish;

   // decision results for the request in ST_FINISH
   outcome_type            dec_outcome;
   logic [SLOT_W-1:0]      dec_idx;
   logic [SCORE_W-1:0]     dec_score;
   logic [OCC_W-1:0]       occ_in;
   logic [COUNT_W-1:0]     contest_in;
   logic [COUNT_W-1:0]     evict_in;
   logic [SLOT_W-1:0]      ptr_in;
   logic [SLOT_W+IDX_FIELD_W-1:0] idx_wide;
   logic [OCC_W+OCC_FIELD_W-1:0]  occ_wide;

   assign accept     = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign finish     = (state_ff == ST_FINISH) && out_free;

   // Launch the search token into the first cell on accept; mask the key.
   always_comb begin
      launch        = '0;
      launch.active = accept;
      launch.key    = req_if.key[KEY_W-1:0];
      launch.delta  = req_if.increment;
      launch.victim = ptr_ff;
   end

   assign chain[0] = launch;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      sadm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .slot_id (SLOT_W'(i)),
         .tok_in  (chain[i]),
         .wr      (wr),
         .tok_out (chain[i+1])
      );
   end

   // Decide the outcome once the token has left the last cell.
   always_comb begin
      wr          = '0;
      dec_outcome = OUT_HIT;
      dec_idx     = tok_done_ff.hit_idx;
      dec_score   = tok_done_ff.hit_score;
      occ_in      = occ_ff;
      contest_in  = contest_ff;
      evict_in    = evict_ff;
      ptr_in      = ptr_ff;

      if (!tok_done_ff.found) begin
         // contest at the victim slot; advance the pointer
         dec_idx    = tok_done_ff.victim;
         contest_in = contest_ff + COUNT_W'(1);
         ptr_in     = (tok_done_ff.victim == SLOT_W'(SLOT_COUNT - 1)) ? '0
                      : tok_done_ff.victim + SLOT_W'(1);
         wr.en      = 1'b1;
         wr.idx     = tok_done_ff.victim;
         wr.key     = tok_done_ff.key;
         if (!tok_done_ff.vic_valid) begin
            dec_outcome = OUT_ADMIT;
            dec_score   = {{(SCORE_W - DELTA_W){1'b0}}, tok_done_ff.delta};
            wr.load_key = 1'b1;
            occ_in      = occ_ff + OCC_W'(1);
         end else if ({{(SCORE_W - DELTA_W){1'b0}}, tok_done_ff.delta}
                      > tok_done_ff.vic_score) begin
            dec_outcome = OUT_EVICT;
            dec_score   = {{(SCORE_W - DELTA_W){1'b0}}, tok_done_ff.delta};
            wr.load_key = 1'b1;
            evict_in    = evict_ff + COUNT_W'(1);
         end else begin
            // reject: drop the score by one, floored at zero
            dec_outcome = OUT_REJECT;
            dec_score   = (tok_done_ff.vic_score == '0) ? '0
                          : tok_done_ff.vic_score - SCORE_W'(1);
         end
         wr.score = dec_score;
      end
      wr.en = wr.en && finish;

      idx_wide = {{IDX_FIELD_W{1'b0}}, dec_idx};
      occ_wide = {{OCC_FIELD_W{1'b0}}, occ_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         occ_ff       <= '0;
         contest_ff   <= '0;
         evict_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop a taken response unless a new one loads in this cycle
         if (rsp_valid_ff && rsp_if.ready && !finish) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_SWEEP;
               end
            end
            ST_SWEEP: begin
               // hold the token as it leaves the row
               if (chain[SLOT_COUNT].active) begin
                  tok_done_ff <= chain[SLOT_COUNT];
                  state_ff    <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  ptr_ff         <= ptr_in;
                  occ_ff         <= occ_in;
                  contest_ff     <= contest_in;
                  evict_ff       <= evict_in;
                  rsp_valid_ff   <= 1'b1;
                  outcome_ff     <= dec_outcome;
                  slot_index_ff  <= idx_wide[IDX_FIELD_W-1:0];
                  slot_score_ff  <= dec_score;
                  occ_out_ff     <= occ_wide[OCC_FIELD_W-1:0];
                  contest_out_ff <= contest_in;
                  evict_out_ff   <= evict_in;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.outcome        = outcome_ff;
   assign rsp_if.slot_index     = slot_index_ff;
   assign rsp_if.slot_score     = slot_score_ff;
   assign rsp_if.slots_occupied = occ_out_ff;
   assign rsp_if.contest_total  = contest_out_ff;
   assign rsp_if.eviction_total = evict_out_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(SLOT_COUNT))
      else $error("occupancy above slot count");

   a_token_in_sweep: assert property (@(posedge clock) disable iff (reset)
      chain[SLOT_COUNT].active |-> state_ff == ST_SWEEP)
      else $error("search token left the row outside the sweep");

   a_accept_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SWEEP)
      else $error("accepted request did not start a sweep");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |=> rsp_valid_ff && $stable(slot_score_ff))
      else $error("pending response overwritten");

endmodule
